>>> hw/rtl/dlts_pkg.sv
package dlts_pkg;

  localparam int MaxTasksDef = 8;
  localparam int MsPerTickDef = 10;
  localparam int DeltaW = 13;
  localparam int PeriodW = 16;
  localparam int TagW = 8;
  localparam int SlotIdW = 3;
  localparam int ResultCap = 8;
  localparam logic [DeltaW-1:0] DeltaMax = 13'd8191;

  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpAdd = 2'd1;
  localparam logic [1:0] OpDispatch = 2'd2;
  localparam logic [1:0] OpNone = 2'd3;

  typedef struct packed {
    logic [DeltaW-1:0]  delta;
    logic [PeriodW-1:0] period;
    logic [TagW-1:0]    tag;
    logic [5:0]         slot;
  } entry_t;

  // Commands from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift_in;    // insert: cells behind the insert point pass their entry one place down
    logic pop;         // all cells take their successor's entry
    logic tick;        // head cell counts its delta down
  } cell_cmd_t;

endpackage

>>> hw/rtl/delta_list_task_scheduler.sv
// Delta-list timer queue. Input words carry an operation (tick, add, dispatch),
// a tag, a delay and a period in milliseconds. A tick produces no output word.
// An add produces one status word with the slot given, or a full flag. A
// dispatch produces one word for each due head entry, at most eight, with
// tlast on the final one; periodic tasks are re-inserted as they leave.
// The list is a chain of cells, one entry each. An add walks the chain one
// cell a cycle to find the insert point, then shifts all later cells down
// together. A dispatch pops one head per word, plus a walk for each
// re-inserted task. The block takes one input word at a time and is ready
// again once its last output word is taken. When the receiver stalls, the
// output word holds and the sequencer waits. Reset empties the list and
// frees all slots; entry contents are not cleared.
module delta_list_task_scheduler #(
  parameter int MAX_TASKS   = dlts_pkg::MaxTasksDef,
  parameter int MS_PER_TICK = dlts_pkg::MsPerTickDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation[1:0], task_tag[9:2], delay_ms[25:10],
                                  // period_ms[41:26], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // add_status[0], due_tag[8:1], slot_id[11:9], zero fill
  output logic        out_tuser,  // result_kind
  output logic        out_tlast
);
  import dlts_pkg::*;

  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LenW = $clog2(MAX_TASKS + 1);
  localparam int RecShift = 16 + $clog2(MS_PER_TICK);
  localparam logic [17:0] RecMul =
      18'(((64'd1 << RecShift) / 64'(MS_PER_TICK)) + 64'd1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_INS   = 7'b0000100,
    S_OUT   = 7'b0001000,
    S_DISP  = 7'b0010000,
    S_REDO  = 7'b0100000,
    S_TICK  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  entry_t cells [MAX_TASKS];
  logic [MAX_TASKS-1:0] busy_r, busy_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [IdxW:0] pos_r, pos_nxt;
  logic [DeltaW-1:0] rem_r, rem_nxt;
  entry_t new_r, new_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] due_r, due_nxt;
  logic [1:0] op_r, op_nxt;
  logic o_valid_r, o_valid_nxt, o_kind_r, o_kind_nxt, o_stat_r, o_stat_nxt;
  logic o_last_r, o_last_nxt;
  logic [TagW-1:0] o_tag_r, o_tag_nxt;
  logic [SlotIdW-1:0] o_slot_r, o_slot_nxt;
  cell_cmd_t cmd;
  logic [DeltaW-1:0] ticks_w;
  logic [15:0] ms_w;
  logic free_found;
  logic [IdxW-1:0] free_idx;
  entry_t head;

  assign ms_w = (state_r == S_IDLE) ? in_tdata[25:10] : head.period;

  // Division by the tick length through a rounded-up reciprocal, exact for
  // every 16-bit input.
  function automatic logic [DeltaW-1:0] to_ticks(input logic [15:0] ms);
    logic [33:0] prod;
    logic [15:0] q;
    prod = {18'd0, ms} * {16'd0, RecMul};
    q = 16'(prod >> RecShift);
    return (q > 16'(DeltaMax)) ? DeltaMax : q[DeltaW-1:0];
  endfunction

  assign ticks_w = to_ticks(ms_w);
  assign head = cells[0];

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      dlts_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .is_head    (g == 0),
        .here       (pos_r == (IdxW+1)'(g)),
        .after      (pos_r < (IdxW+1)'(g) && (LenW+1)'(g) <= (LenW+1)'(len_r)),
        .fix        (pos_r + 1'b1 == (IdxW+1)'(g) && (LenW+1)'(g) <= (LenW+1)'(len_r)),
        .new_entry  (new_r),
        .prev_entry (cells[(g == 0) ? 0 : g - 1]),
        .next_entry (cells[(g == MAX_TASKS - 1) ? g : g + 1]),
        .entry      (cells[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    busy_nxt = busy_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    new_nxt = new_r;
    cnt_nxt = cnt_r;
    op_nxt = op_r;
    o_valid_nxt = o_valid_r;
    o_kind_nxt = o_kind_r;
    o_stat_nxt = o_stat_r;
    o_last_nxt = o_last_r;
    o_tag_nxt = o_tag_r;
    o_slot_nxt = o_slot_r;
    cmd = '0;
    in_tready = (state_r == S_IDLE) && !o_valid_r;
    if (o_valid_r && out_tready) begin
      o_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_tdata[1:0];
          cnt_nxt = '0;
          case (in_tdata[1:0])
            OpTick: state_nxt = S_TICK;
            OpAdd: begin
              o_kind_nxt = 1'b0;
              o_tag_nxt = in_tdata[9:2];
              o_last_nxt = 1'b1;
              if (free_found) begin
                busy_nxt[free_idx] = 1'b1;
                o_stat_nxt = 1'b0;
                o_slot_nxt = SlotIdW'(free_idx);
                new_nxt.tag = in_tdata[9:2];
                new_nxt.period = in_tdata[41:26];
                new_nxt.slot = 6'(free_idx);
                rem_nxt = ticks_w;
                pos_nxt = '0;
                state_nxt = S_WALK;
              end else begin
                o_stat_nxt = 1'b1;
                o_slot_nxt = '0;
                state_nxt = S_OUT;
              end
            end
            OpDispatch: state_nxt = S_DISP;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        cmd.tick = (len_r != '0);
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        if ((LenW+1)'(pos_r) < (LenW+1)'(len_r) && rem_r >= cells[pos_r[IdxW-1:0]].delta) begin
          rem_nxt = rem_r - cells[pos_r[IdxW-1:0]].delta;
          pos_nxt = pos_r + 1'b1;
        end else begin
          new_nxt.delta = rem_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.shift_in = 1'b1;
        len_nxt = len_r + 1'b1;
        state_nxt = (op_r == OpDispatch) ? S_DISP : S_OUT;
      end
      S_OUT: begin
        if (!o_valid_r || out_tready) begin
          o_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        if (cnt_r == due_r) begin
          state_nxt = S_IDLE;
        end else if (!o_valid_r || out_tready) begin
          o_valid_nxt = 1'b1;
          o_kind_nxt = 1'b1;
          o_stat_nxt = 1'b0;
          o_tag_nxt = head.tag;
          o_slot_nxt = head.slot[SlotIdW-1:0];
          o_last_nxt = (cnt_r + 4'd1 == due_r);
          busy_nxt[head.slot[IdxW-1:0]] = 1'b0;
          cmd.pop = 1'b1;
          len_nxt = len_r - 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          new_nxt = head;
          rem_nxt = ticks_w;
          if (head.period != '0) begin
            state_nxt = S_REDO;
          end
        end
      end
      S_REDO: begin
        if (free_found) begin
          busy_nxt[free_idx] = 1'b1;
          new_nxt.slot = 6'(free_idx);
          pos_nxt = '0;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_DISP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The number of due entries is fixed when the dispatch is taken, so a
  // re-added task with a zero delay waits for the next dispatch.
  always_comb begin
    due_nxt = due_r;
    if (state_r == S_IDLE && in_tvalid && in_tready && in_tdata[1:0] == OpDispatch) begin
      due_nxt = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (i < ResultCap && (LenW+1)'(i) < (LenW+1)'(len_r) && due_nxt == 4'(i) &&
            cells[i].delta == '0) begin
          due_nxt = due_nxt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= '0;
      len_r <= '0;
      o_valid_r <= 1'b0;
      cnt_r <= '0;
      due_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
      len_r <= len_nxt;
      o_valid_r <= o_valid_nxt;
      cnt_r <= cnt_nxt;
      due_r <= due_nxt;
    end
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    new_r <= new_nxt;
    op_r <= op_nxt;
    o_kind_r <= o_kind_nxt;
    o_stat_r <= o_stat_nxt;
    o_tag_r <= o_tag_nxt;
    o_slot_r <= o_slot_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_valid_r;
  assign out_tuser = o_kind_r;
  assign out_tlast = o_last_r;
  assign out_tdata = {4'b0, o_slot_r, o_tag_r, o_stat_r};

endmodule

>>> hw/rtl/dlts_cell.sv
module dlts_cell (
  input  logic              clk,
  input  dlts_pkg::cell_cmd_t cmd,
  input  logic              is_head,
  input  logic              here,       // new entry lands in this cell
  input  logic              after,      // this cell sits behind the insert point
  input  logic              fix,        // this cell is the successor of the new entry
  input  dlts_pkg::entry_t  new_entry,
  input  dlts_pkg::entry_t  prev_entry,
  input  dlts_pkg::entry_t  next_entry,
  output dlts_pkg::entry_t  entry
);
  import dlts_pkg::*;

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = next_entry;
    end else if (cmd.shift_in) begin
      if (here) begin
        entry_nxt = new_entry;
      end else if (after) begin
        entry_nxt = prev_entry;
      end
      if (fix) begin
        entry_nxt.delta = prev_entry.delta - new_entry.delta;
      end
    end else if (cmd.tick && is_head && entry_r.delta != '0) begin
      entry_nxt.delta = entry_r.delta - DeltaW'(1);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
